@@ rtl/lbx_pkg.sv @@
// shared constants, types and helpers for the letterbox pixel mapper
`default_nettype none

package lbx_pkg;

    // geometry limits and fixed-point format
    localparam int MAX_DIM    = 4096;
    localparam int FRAC_BITS  = 4;
    localparam int DIM_W      = $clog2(MAX_DIM + 1);
    localparam int REG_W      = DIM_W + FRAC_BITS;

    // beat field widths
    localparam int PIN_W      = 16;
    localparam int COORD_W    = 12;
    localparam int IDX_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // per-point divider geometry
    localparam int NUM_W      = PIN_W + DIM_W;
    localparam int DREM_W     = NUM_W - COORD_W;
    localparam int DIV_BITS   = 2;
    localparam int DIV_STAGES = COORD_W / DIV_BITS;

    // configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_W  = CFG_IDX_W'(0),
        REG_SRC_H  = CFG_IDX_W'(1),
        REG_CAN_W  = CFG_IDX_W'(2),
        REG_CAN_H  = CFG_IDX_W'(3),
        REG_FRAME  = CFG_IDX_W'(4)
    } lbx_reg_idx_t;

    // status handed from the fit unit to the point pipeline
    typedef struct packed {
        logic             busy;
        logic             frame_ready;
        logic [DIM_W-1:0] src_w;
        logic [DIM_W-1:0] src_h;
    } lbx_fit_st_t;

    // fitted region, all values in canvas fixed point
    typedef struct packed {
        logic [REG_W-1:0] rw;
        logic [REG_W-1:0] rh;
        logic [REG_W-1:0] sx;
        logic [REG_W-1:0] sy;
        logic [REG_W-1:0] cwf;
        logic [REG_W-1:0] chf;
    } lbx_region_t;

    // zero reads as one, oversize saturates
    function automatic logic [DIM_W-1:0] eff_size(input logic [CFG_DATA_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end
        else if (v > CFG_DATA_W'(MAX_DIM)) begin
            res = DIM_W'(MAX_DIM);
        end
        else begin
            res = DIM_W'(v);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/lbx_if.sv @@
// valid/ready channel interfaces for configuration, points and pixels
`default_nettype none

interface lbx_cfg_if import lbx_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface lbx_point_if import lbx_pkg::*;;
    logic             valid;
    logic             ready;
    logic [PIN_W-1:0] pin_x;
    logic [PIN_W-1:0] pin_y;

    modport source (output valid, output pin_x, output pin_y, input ready);
    modport sink   (input valid, input pin_x, input pin_y, output ready);
endinterface

interface lbx_pixel_if import lbx_pkg::*;;
    logic               valid;
    logic               ready;
    logic               inside_res;
    logic [COORD_W-1:0] pixel_col;
    logic [COORD_W-1:0] pixel_row;
    logic [IDX_W-1:0]   pixel_index;

    modport source (output valid, output inside_res, output pixel_col, output pixel_row,
                    output pixel_index, input ready);
    modport sink   (input valid, input inside_res, input pixel_col, input pixel_row,
                    input pixel_index, output ready);
endinterface

`default_nettype wire

@@ rtl/lbx_fit.sv @@
// configuration registers and the sequential aspect-fit region calculator
`default_nettype none

module lbx_fit import lbx_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output lbx_fit_st_t           fit_st,
    output lbx_region_t           region
);

    localparam int PROD_W = 2 * DIM_W;
    localparam int NUMF_W = PROD_W + FRAC_BITS;
    localparam int ITER_W = $clog2(NUMF_W);

    typedef enum logic [4:0] {
        FIT_IDLE = 5'b00001,
        FIT_MUL  = 5'b00010,
        FIT_LOAD = 5'b00100,
        FIT_DIV  = 5'b01000,
        FIT_FIN  = 5'b10000
    } lbx_fit_state_t;

    lbx_fit_state_t    state_reg, state_next;
    logic [DIM_W-1:0]  src_w_reg, src_w_next;
    logic [DIM_W-1:0]  src_h_reg, src_h_next;
    logic [DIM_W-1:0]  can_w_reg, can_w_next;
    logic [DIM_W-1:0]  can_h_reg, can_h_next;
    logic              frame_reg, frame_next;
    logic [REG_W-1:0]  rw_reg, rw_next;
    logic [REG_W-1:0]  rh_reg, rh_next;
    logic [REG_W-1:0]  sx_reg, sx_next;
    logic [REG_W-1:0]  sy_reg, sy_next;
    logic [ITER_W-1:0] cnt_reg, cnt_next;

    logic [PROD_W-1:0] prod_a_reg, prod_a_next;
    logic [PROD_W-1:0] prod_b_reg, prod_b_next;
    logic              pillar_reg, pillar_next;
    logic [NUMF_W-1:0] quo_reg, quo_next;
    logic [DIM_W-1:0]  rem_reg, rem_next;
    logic [DIM_W-1:0]  den_reg, den_next;

    logic [REG_W-1:0]  cwf;
    logic [REG_W-1:0]  chf;
    logic [DIM_W:0]    trial;
    logic [NUMF_W-1:0] shifted;
    logic [NUMF_W-1:0] rw_full;
    logic [NUMF_W-1:0] rh_full;

    // canvas extent in fixed point
    assign cwf = REG_W'(can_w_reg) << FRAC_BITS;
    assign chf = REG_W'(can_h_reg) << FRAC_BITS;

    // register writes and the fit sequence: products, compare, long division, centring
    always_comb
    begin
        state_next  = state_reg;
        src_w_next  = src_w_reg;
        src_h_next  = src_h_reg;
        can_w_next  = can_w_reg;
        can_h_next  = can_h_reg;
        frame_next  = frame_reg;
        rw_next     = rw_reg;
        rh_next     = rh_reg;
        sx_next     = sx_reg;
        sy_next     = sy_reg;
        cnt_next    = cnt_reg;
        prod_a_next = prod_a_reg;
        prod_b_next = prod_b_reg;
        pillar_next = pillar_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        den_next    = den_reg;
        trial       = '0;
        shifted     = '0;
        rw_full     = '0;
        rh_full     = '0;

        if (wr_en)
        begin
            case (wr_index)
                REG_SRC_W:
                begin
                    src_w_next = eff_size(wr_data);
                    state_next = FIT_MUL;
                end
                REG_SRC_H:
                begin
                    src_h_next = eff_size(wr_data);
                    state_next = FIT_MUL;
                end
                REG_CAN_W:
                begin
                    can_w_next = eff_size(wr_data);
                    state_next = FIT_MUL;
                end
                REG_CAN_H:
                begin
                    can_h_next = eff_size(wr_data);
                    state_next = FIT_MUL;
                end
                REG_FRAME:
                begin
                    frame_next = wr_data[0];
                end
                default:
                begin
                end
            endcase
        end

        case (state_reg)
            FIT_IDLE:
            begin
            end
            FIT_MUL:
            begin
                prod_a_next = {{DIM_W{1'b0}}, src_w_reg} * {{DIM_W{1'b0}}, can_h_reg};
                prod_b_next = {{DIM_W{1'b0}}, can_w_reg} * {{DIM_W{1'b0}}, src_h_reg};
                state_next  = FIT_LOAD;
            end
            FIT_LOAD:
            begin
                pillar_next = (prod_a_reg <= prod_b_reg);
                if (prod_a_reg <= prod_b_reg)
                begin
                    quo_next = NUMF_W'(prod_a_reg) << FRAC_BITS;
                    den_next = src_h_reg;
                end
                else
                begin
                    quo_next = NUMF_W'(prod_b_reg) << FRAC_BITS;
                    den_next = src_w_reg;
                end
                rem_next   = '0;
                cnt_next   = ITER_W'(NUMF_W - 1);
                state_next = FIT_DIV;
            end
            FIT_DIV:
            begin
                // one quotient bit per cycle
                trial   = {rem_reg, quo_reg[NUMF_W-1]};
                shifted = quo_reg << 1;
                if (trial >= {1'b0, den_reg})
                begin
                    trial      = trial - {1'b0, den_reg};
                    shifted[0] = 1'b1;
                end
                rem_next = trial[DIM_W-1:0];
                quo_next = shifted;
                if (cnt_reg == '0)
                begin
                    state_next = FIT_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg - ITER_W'(1);
                end
            end
            FIT_FIN:
            begin
                rw_full = pillar_reg ? quo_reg : NUMF_W'(cwf);
                rh_full = pillar_reg ? NUMF_W'(chf) : quo_reg;
                if (rw_full > NUMF_W'(cwf))
                begin
                    rw_full = NUMF_W'(cwf);
                end
                if (rh_full > NUMF_W'(chf))
                begin
                    rh_full = NUMF_W'(chf);
                end
                rw_next    = rw_full[REG_W-1:0];
                rh_next    = rh_full[REG_W-1:0];
                sx_next    = (cwf - rw_full[REG_W-1:0]) >> 1;
                sy_next    = (chf - rh_full[REG_W-1:0]) >> 1;
                state_next = FIT_IDLE;
            end
            default:
            begin
                state_next = FIT_IDLE;
            end
        endcase
    end

    // control and architectural state, reset gives a 1x1 fit at the origin
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FIT_IDLE;
            src_w_reg <= DIM_W'(1);
            src_h_reg <= DIM_W'(1);
            can_w_reg <= DIM_W'(1);
            can_h_reg <= DIM_W'(1);
            frame_reg <= 1'b0;
            rw_reg    <= REG_W'(1) << FRAC_BITS;
            rh_reg    <= REG_W'(1) << FRAC_BITS;
            sx_reg    <= '0;
            sy_reg    <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            src_w_reg <= src_w_next;
            src_h_reg <= src_h_next;
            can_w_reg <= can_w_next;
            can_h_reg <= can_h_next;
            frame_reg <= frame_next;
            rw_reg    <= rw_next;
            rh_reg    <= rh_next;
            sx_reg    <= sx_next;
            sy_reg    <= sy_next;
            cnt_reg   <= cnt_next;
        end
    end

    // divider working registers
    always_ff @(posedge clk)
    begin
        prod_a_reg <= prod_a_next;
        prod_b_reg <= prod_b_next;
        pillar_reg <= pillar_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        den_reg    <= den_next;
    end

    // status and region out
    assign fit_st.busy        = (state_reg != FIT_IDLE);
    assign fit_st.frame_ready = frame_reg;
    assign fit_st.src_w       = src_w_reg;
    assign fit_st.src_h       = src_h_reg;

    assign region.rw  = rw_reg;
    assign region.rh  = rh_reg;
    assign region.sx  = sx_reg;
    assign region.sy  = sy_reg;
    assign region.cwf = cwf;
    assign region.chf = chf;

endmodule

`default_nettype wire

@@ rtl/lbx_div_pipe.sv @@
// pipelined restoring divider, two quotient bits per stage
`default_nettype none

module lbx_div_pipe import lbx_pkg::*;
(
    input  logic                  clk,
    input  logic [DIV_STAGES-1:0] en,
    input  logic [NUM_W-1:0]      num,
    input  logic [REG_W-1:0]      den,
    output logic [COORD_W-1:0]    quo
);

    // rem holds the partial remainder, q the unused dividend bits then quotient bits
    logic [DREM_W-1:0]  rem_reg [DIV_STAGES];
    logic [COORD_W-1:0] q_reg   [DIV_STAGES];
    logic [DREM_W-1:0]  rem_in  [DIV_STAGES];
    logic [COORD_W-1:0] q_in    [DIV_STAGES];
    logic [DREM_W-1:0]  rem_w   [DIV_STAGES];
    logic [COORD_W-1:0] q_w     [DIV_STAGES];

    // one compare and subtract
    function automatic logic [DREM_W+COORD_W-1:0] div_step(
        input logic [DREM_W-1:0]  rem,
        input logic [COORD_W-1:0] q,
        input logic [REG_W-1:0]   d
    );
        logic [DREM_W:0]    r;
        logic [DREM_W:0]    dd;
        logic [COORD_W-1:0] qn;
        r  = {rem, q[COORD_W-1]};
        dd = (DREM_W+1)'(d);
        qn = q << 1;
        if (r >= dd)
        begin
            r     = r - dd;
            qn[0] = 1'b1;
        end
        return {r[DREM_W-1:0], qn};
    endfunction

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        // stage input, the quotient is known to fit so the top bits start below den
        if (k == 0)
        begin : g_first
            assign rem_in[k] = num[NUM_W-1:COORD_W];
            assign q_in[k]   = num[COORD_W-1:0];
        end
        else
        begin : g_next
            assign rem_in[k] = rem_reg[k-1];
            assign q_in[k]   = q_reg[k-1];
        end

        always_comb
        begin
            rem_w[k] = rem_in[k];
            q_w[k]   = q_in[k];
            for (int b = 0; b < DIV_BITS; b++)
            begin
                {rem_w[k], q_w[k]} = div_step(rem_w[k], q_w[k], den);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                rem_reg[k] <= rem_w[k];
                q_reg[k]   <= q_w[k];
            end
        end
    end

    assign quo = q_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

@@ rtl/letterbox_nearest_pixel_mapper.sv @@
// a point's result passes through 9 register stages: compare, multiply, the divider stages, output
// throughput: one point per cycle while the fit unit is idle; stalls hold each stage, bubbles are squeezed out
// a write to a size register starts the fit unit's serial divider: a multiply, a load,
//   30 division steps and a centring step, with point and cfg ready low
// reset: sizes 1, frame not ready, region 1.0 x 1.0 at the origin, pipeline empty
`default_nettype none

module letterbox_nearest_pixel_mapper import lbx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    lbx_cfg_if.sink     cfg,
    lbx_point_if.sink   point,
    lbx_pixel_if.source pixel
);

    localparam int NSTG   = DIV_STAGES + 3;
    localparam int S_DIV0 = 2;
    localparam int S_OUT  = NSTG - 1;

    lbx_fit_st_t fit_st;
    lbx_region_t region;

    logic [NSTG-1:0] stage_v_reg, stage_v_next;
    logic [NSTG-1:0] stage_en;
    logic            accept;

    logic [REG_W:0]   px_e, py_e, sx_e, sy_e, end_x, end_y, diff_x, diff_y;
    logic             hit_x, hit_y;
    logic             cmp_inside_reg;
    logic [PIN_W-1:0] cmp_dx_reg, cmp_dy_reg;

    logic [DIM_W-1:0] sw_m1, sh_m1;
    logic             mul_inside_reg;
    logic [NUM_W-1:0] mul_num_x_reg, mul_num_y_reg;

    logic               div_inside_reg [DIV_STAGES];
    logic [COORD_W-1:0] quo_x, quo_y;

    logic [COORD_W-1:0]       col_w, row_w;
    logic [COORD_W+DIM_W-1:0] idx_full;
    logic                     out_inside_reg;
    logic [COORD_W-1:0]       out_col_reg, out_row_reg;
    logic [IDX_W-1:0]         out_idx_reg;

    // configuration and region fit
    assign cfg.ready = !fit_st.busy;

    lbx_fit u_fit
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid && cfg.ready),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .fit_st   (fit_st),
        .region   (region)
    );

    // stage enables: a stage moves when it is empty or the one after it moves
    always_comb
    begin
        stage_en[S_OUT] = !stage_v_reg[S_OUT] || pixel.ready;
        for (int k = S_OUT - 1; k >= 0; k--)
        begin
            stage_en[k] = !stage_v_reg[k] || stage_en[k+1];
        end
    end

    assign point.ready = stage_en[0] && !fit_st.busy;
    assign accept      = point.valid && point.ready;

    // valid bits travel with the data
    always_comb
    begin
        stage_v_next = stage_v_reg;
        if (stage_en[0])
        begin
            stage_v_next[0] = accept;
        end
        for (int k = 1; k < NSTG; k++)
        begin
            if (stage_en[k])
            begin
                stage_v_next[k] = stage_v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_v_reg <= '0;
        end
        else
        begin
            stage_v_reg <= stage_v_next;
        end
    end

    // stage 1: region bounds check and offset from the region start
    always_comb
    begin
        px_e   = (REG_W+1)'(point.pin_x);
        py_e   = (REG_W+1)'(point.pin_y);
        sx_e   = (REG_W+1)'(region.sx);
        sy_e   = (REG_W+1)'(region.sy);
        end_x  = sx_e + (REG_W+1)'(region.rw);
        end_y  = sy_e + (REG_W+1)'(region.rh);
        hit_x  = (px_e >= sx_e) && (px_e <= end_x);
        hit_y  = (py_e >= sy_e) && (py_e <= end_y);
        diff_x = px_e - sx_e;
        diff_y = py_e - sy_e;
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            cmp_inside_reg <= fit_st.frame_ready && hit_x && hit_y;
            cmp_dx_reg     <= diff_x[PIN_W-1:0];
            cmp_dy_reg     <= diff_y[PIN_W-1:0];
        end
    end

    // stage 2: scale the offset by the source size minus one
    assign sw_m1 = fit_st.src_w - DIM_W'(1);
    assign sh_m1 = fit_st.src_h - DIM_W'(1);

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            mul_inside_reg <= cmp_inside_reg;
            mul_num_x_reg  <= NUM_W'(cmp_dx_reg) * NUM_W'(sw_m1);
            mul_num_y_reg  <= NUM_W'(cmp_dy_reg) * NUM_W'(sh_m1);
        end
    end

    // divide by the region extent, one divider per axis
    lbx_div_pipe u_div_x
    (
        .clk (clk),
        .en  (stage_en[S_DIV0 +: DIV_STAGES]),
        .num (mul_num_x_reg),
        .den (region.rw),
        .quo (quo_x)
    );

    lbx_div_pipe u_div_y
    (
        .clk (clk),
        .en  (stage_en[S_DIV0 +: DIV_STAGES]),
        .num (mul_num_y_reg),
        .den (region.rh),
        .quo (quo_y)
    );

    // inside flag alongside the divider stages
    always_ff @(posedge clk)
    begin
        if (stage_en[S_DIV0])
        begin
            div_inside_reg[0] <= mul_inside_reg;
        end
        for (int k = 1; k < DIV_STAGES; k++)
        begin
            if (stage_en[S_DIV0 + k])
            begin
                div_inside_reg[k] <= div_inside_reg[k-1];
            end
        end
    end

    // output stage: zero-extent axes map to 0, then the linear index
    always_comb
    begin
        col_w    = (region.rw == '0) ? '0 : quo_x;
        row_w    = (region.rh == '0) ? '0 : quo_y;
        idx_full = (COORD_W+DIM_W)'(row_w) * (COORD_W+DIM_W)'(fit_st.src_w)
                 + (COORD_W+DIM_W)'(col_w);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[S_OUT])
        begin
            if (div_inside_reg[DIV_STAGES-1])
            begin
                out_inside_reg <= 1'b1;
                out_col_reg    <= col_w;
                out_row_reg    <= row_w;
                out_idx_reg    <= idx_full[IDX_W-1:0];
            end
            else
            begin
                out_inside_reg <= 1'b0;
                out_col_reg    <= '0;
                out_row_reg    <= '0;
                out_idx_reg    <= '0;
            end
        end
    end

    assign pixel.valid       = stage_v_reg[S_OUT];
    assign pixel.inside_res  = out_inside_reg;
    assign pixel.pixel_col   = out_col_reg;
    assign pixel.pixel_row   = out_row_reg;
    assign pixel.pixel_index = out_idx_reg;

    // an outside beat carries all-zero coordinates
    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        pixel.valid && !pixel.inside_res |->
            pixel.pixel_col == '0 && pixel.pixel_row == '0 && pixel.pixel_index == '0)
        else $error("outside beat with non-zero coordinates");

    // outside a refit the centred region never runs past the canvas
    a_region_fits: assert property (@(posedge clk) disable iff (!rst_n)
        !fit_st.busy |->
            ((REG_W+1)'(region.sx) + (REG_W+1)'(region.rw)) <= (REG_W+1)'(region.cwf) &&
            ((REG_W+1)'(region.sy) + (REG_W+1)'(region.rh)) <= (REG_W+1)'(region.chf))
        else $error("fitted region exceeds canvas");

    // a size write blocks points while the region is recomputed
    a_refit_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.valid && cfg.ready &&
        (cfg.index == REG_SRC_W || cfg.index == REG_SRC_H ||
         cfg.index == REG_CAN_W || cfg.index == REG_CAN_H) |=>
            fit_st.busy && !point.ready)
        else $error("points accepted during region refit");

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// self-checking testbench for the letterbox nearest pixel mapper
module testbench import lbx_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY        = 9;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PRESSURE_ITEMS = 80;
    localparam int RANDOM_ROUNDS  = 12;
    localparam int ROUND_ITEMS    = 110;
    localparam int MAX_REPORTS    = 10;

    // indexes past the end of the register map, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO  = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_MID = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI  = CFG_IDX_W'(7);

    typedef struct packed {
        logic               in_region;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [IDX_W-1:0]   idx;
    } pixel_beat_t;

    logic clk;
    logic rst_n;

    lbx_cfg_if   cfg_ch ();
    lbx_point_if pt_ch ();
    lbx_pixel_if px_ch ();

    letterbox_nearest_pixel_mapper dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .point (pt_ch),
        .pixel (px_ch)
    );

    // mirrored register file and fitted region
    logic [CFG_DATA_W-1:0] src_w_reg = CFG_DATA_W'(1);
    logic [CFG_DATA_W-1:0] src_h_reg = CFG_DATA_W'(1);
    logic [CFG_DATA_W-1:0] can_w_reg = CFG_DATA_W'(1);
    logic [CFG_DATA_W-1:0] can_h_reg = CFG_DATA_W'(1);
    logic                  frame_on  = 1'b0;
    bit [63:0]             fit_w;
    bit [63:0]             fit_h;
    bit [63:0]             fit_x0;
    bit [63:0]             fit_y0;

    pixel_beat_t pending_pixels[$];
    int          mismatches    = 0;
    int          beats_seen    = 0;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int          hold_left     = 0;
    int          idle_cycles   = 0;

    // zero reads as one, oversize saturates
    function automatic bit [63:0] clamp_dim(logic [CFG_DATA_W-1:0] v);
        if (v == '0)
        begin
            return 64'd1;
        end
        if (v > MAX_DIM)
        begin
            return 64'(MAX_DIM);
        end
        return 64'(v);
    endfunction

    // aspect fit and centring of the region
    function automatic void refit();
        bit [63:0] sw;
        bit [63:0] sh;
        bit [63:0] cw;
        bit [63:0] ch;
        bit [63:0] cwf;
        bit [63:0] chf;
        sw  = clamp_dim(src_w_reg);
        sh  = clamp_dim(src_h_reg);
        cw  = clamp_dim(can_w_reg);
        ch  = clamp_dim(can_h_reg);
        cwf = cw << FRAC_BITS;
        chf = ch << FRAC_BITS;
        if (sw * ch <= cw * sh)
        begin
            fit_w = ((ch * sw) << FRAC_BITS) / sh;
            fit_h = chf;
        end
        else
        begin
            fit_w = cwf;
            fit_h = ((cw * sh) << FRAC_BITS) / sw;
        end
        if (fit_w > cwf)
        begin
            fit_w = cwf;
        end
        if (fit_h > chf)
        begin
            fit_h = chf;
        end
        fit_x0 = (cwf - fit_w) >> 1;
        fit_y0 = (chf - fit_h) >> 1;
    endfunction

    function automatic void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_SRC_W: src_w_reg = data;
            REG_SRC_H: src_h_reg = data;
            REG_CAN_W: can_w_reg = data;
            REG_CAN_H: can_h_reg = data;
            REG_FRAME: frame_on  = data[0];
            default: ;
        endcase
        refit();
    endfunction

    // one axis: bounds inclusive, zero extent maps to coordinate 0
    function automatic bit locate(bit [63:0] p, bit [63:0] origin, bit [63:0] extent,
                                  bit [63:0] dim, output bit [63:0] coord);
        coord = 0;
        if (p < origin || p > origin + extent)
        begin
            return 1'b0;
        end
        if (extent != 0)
        begin
            coord = ((p - origin) * (dim - 1)) / extent;
        end
        return 1'b1;
    endfunction

    function automatic pixel_beat_t map_point(logic [PIN_W-1:0] px, logic [PIN_W-1:0] py);
        pixel_beat_t beat;
        bit [63:0]   col;
        bit [63:0]   row;
        bit [63:0]   sw;
        bit [63:0]   sh;
        beat = '0;
        sw   = clamp_dim(src_w_reg);
        sh   = clamp_dim(src_h_reg);
        if (!frame_on)
        begin
            return beat;
        end
        if (!locate(64'(px), fit_x0, fit_w, sw, col))
        begin
            return beat;
        end
        if (!locate(64'(py), fit_y0, fit_h, sh, row))
        begin
            return beat;
        end
        beat.in_region = 1'b1;
        beat.col       = COORD_W'(col);
        beat.row       = COORD_W'(row);
        beat.idx       = IDX_W'(row * sw + col);
        return beat;
    endfunction

    // mostly inside the region, some on and just past its edges, some anywhere
    function automatic logic [PIN_W-1:0] pick_coord(bit [63:0] origin, bit [63:0] extent);
        int unsigned sel;
        bit [63:0]   v;
        sel = $urandom_range(99);
        if (sel < 70)
        begin
            v = origin + 64'($urandom_range(32'(extent)));
        end
        else if (sel < 85)
        begin
            case ($urandom_range(3))
                0: v = origin - 1;
                1: v = origin;
                2: v = origin + extent;
                default: v = origin + extent + 1;
            endcase
        end
        else
        begin
            v = 64'($urandom_range(16'hFFFF));
        end
        return PIN_W'(v);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_size();
        case ($urandom_range(9))
            0: return '0;
            1: return CFG_DATA_W'($urandom_range(8191, MAX_DIM + 1));
            2: return CFG_DATA_W'(MAX_DIM);
            3: return CFG_DATA_W'(1);
            4, 5: return CFG_DATA_W'($urandom_range(MAX_DIM, 1));
            default: return CFG_DATA_W'($urandom_range(640, 1));
        endcase
    endfunction

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // result side: random stalls, or a long hold when asked
    initial
    begin
        px_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                px_ch.ready <= 1'b0;
            end
            else
            begin
                px_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // compare each pixel beat with the oldest prediction
    initial
    begin : pixel_checker
        pixel_beat_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && px_ch.valid && px_ch.ready)
            begin
                beats_seen++;
                if (pending_pixels.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("pixel beat %0d arrived with no point outstanding", beats_seen);
                    end
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    if (px_ch.inside_res !== want.in_region || px_ch.pixel_col !== want.col ||
                        px_ch.pixel_row !== want.row || px_ch.pixel_index !== want.idx)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                        begin
                            $display("pixel beat %0d: expected in=%0b col=%0d row=%0d idx=%0d,",
                                     beats_seen, want.in_region, want.col, want.row, want.idx,
                                     " got in=%0b col=%0d row=%0d idx=%0d",
                                     px_ch.inside_res, px_ch.pixel_col, px_ch.pixel_row,
                                     px_ch.pixel_index);
                        end
                    end
                end
            end
        end
    end

    // watchdog on cycles with no beat on any channel
    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (pt_ch.valid && pt_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
                (px_ch.valid && px_ch.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("letterbox_nearest_pixel_mapper verification failed");
        $finish;
    end

    task automatic send_point(logic [PIN_W-1:0] px, logic [PIN_W-1:0] py);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pt_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pt_ch.valid <= 1'b1;
        pt_ch.pin_x <= px;
        pt_ch.pin_y <= py;
        do
            @(posedge clk);
        while (!pt_ch.ready);
        pending_pixels.insert(pending_pixels.size(), map_point(px, py));
    endtask

    // every point gives one pixel beat, so an empty queue means the block is idle
    task automatic drain();
        pt_ch.valid <= 1'b0;
        while (pending_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        apply_write(idx, data);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic fit_image(logic [CFG_DATA_W-1:0] sw, logic [CFG_DATA_W-1:0] sh,
                             logic [CFG_DATA_W-1:0] cw, logic [CFG_DATA_W-1:0] ch);
        drain();
        write_reg(REG_SRC_W, sw);
        write_reg(REG_SRC_H, sh);
        write_reg(REG_CAN_W, cw);
        write_reg(REG_CAN_H, ch);
    endtask

    // region start, far corner, and just past the right edge
    task automatic send_corners();
        send_point(PIN_W'(fit_x0), PIN_W'(fit_y0));
        send_point(PIN_W'(fit_x0 + fit_w), PIN_W'(fit_y0 + fit_h));
        send_point(PIN_W'(fit_x0 + fit_w + 1), PIN_W'(fit_y0));
    endtask

    // frame not ready: all fields zero
    task automatic test_frame_off();
        drain();
        write_reg(REG_FRAME, CFG_DATA_W'(0));
        send_point(16'h0000, 16'h0000);
        send_point(16'h0008, 16'h0008);
        send_point(16'hFFFF, 16'hFFFF);
    endtask

    // reset geometry: one pixel region at the origin
    task automatic test_unit_region();
        drain();
        write_reg(REG_FRAME, CFG_DATA_W'(1));
        send_point(16'h0000, 16'h0000);
        send_point(16'h0010, 16'h0010);
        send_point(16'h0008, 16'h0011);
        send_point(16'h0011, 16'h0008);
    endtask

    // pillar box, then letterbox rows
    task automatic test_fit_modes();
        fit_image(CFG_DATA_W'(640), CFG_DATA_W'(480), CFG_DATA_W'(1920), CFG_DATA_W'(1080));
        send_corners();
        fit_image(CFG_DATA_W'(1920), CFG_DATA_W'(1080), CFG_DATA_W'(640), CFG_DATA_W'(640));
        send_corners();
    endtask

    // full size, zero and oversize registers, zero extent on either axis
    task automatic test_size_extremes();
        fit_image(CFG_DATA_W'(MAX_DIM), CFG_DATA_W'(MAX_DIM), CFG_DATA_W'(MAX_DIM),
                  CFG_DATA_W'(MAX_DIM));
        send_point(16'h0000, 16'h0000);
        send_point(16'hFFFF, 16'hFFFF);
        send_point(16'h8000, 16'h0001);
        fit_image(CFG_DATA_W'(0), CFG_DATA_W'(8191), CFG_DATA_W'(8191), CFG_DATA_W'(0));
        send_corners();
        fit_image(CFG_DATA_W'(MAX_DIM + 1), CFG_DATA_W'(0), CFG_DATA_W'(3), CFG_DATA_W'(5));
        send_corners();
    endtask

    // writes past the register map leave the geometry alone
    task automatic test_unmapped_index();
        drain();
        write_reg(REG_UNMAPPED_LO, CFG_DATA_W'(8191));
        write_reg(REG_UNMAPPED_HI, CFG_DATA_W'(0));
        send_corners();
    endtask

    // result side held off while points keep coming, so the pipeline backs up
    task automatic test_backpressure();
        fit_image(CFG_DATA_W'(MAX_DIM), CFG_DATA_W'(MAX_DIM), CFG_DATA_W'(MAX_DIM),
                  CFG_DATA_W'(MAX_DIM));
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_left     = HOLD_CYCLES;
        for (int i = 0; i < PRESSURE_ITEMS; i++)
        begin
            send_point(PIN_W'($urandom_range(16'hFFFF)), PIN_W'($urandom_range(16'hFFFF)));
        end
    endtask

    // random geometry per round, points aimed at the fitted region
    task automatic test_random();
        for (int r = 0; r < RANDOM_ROUNDS; r++)
        begin
            fit_image(pick_size(), pick_size(), pick_size(), pick_size());
            write_reg(REG_FRAME, CFG_DATA_W'($urandom_range(9) != 0));
            if (r % 3 == 0)
            begin
                write_reg(REG_UNMAPPED_MID, CFG_DATA_W'($urandom_range(8191)));
            end
            case (r % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 84;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 84;
                end
                default:
                begin
                    send_idle_pct = 31;
                    stall_pct     = 31;
                end
            endcase
            for (int i = 0; i < ROUND_ITEMS; i++)
            begin
                send_point(pick_coord(fit_x0, fit_w), pick_coord(fit_y0, fit_h));
            end
        end
    endtask

    // reset, then the tests in turn
    initial
    begin
        rst_n        <= 1'b0;
        pt_ch.valid  <= 1'b0;
        pt_ch.pin_x  <= '0;
        pt_ch.pin_y  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= '0;
        cfg_ch.data  <= '0;
        refit();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_frame_off();
        test_unit_region();
        test_fit_modes();
        test_size_extremes();
        test_unmapped_index();
        test_backpressure();
        test_random();

        drain();
        repeat (2 * LATENCY) @(posedge clk);
        if (mismatches == 0 && pending_pixels.size() == 0)
        begin
            $display("letterbox_nearest_pixel_mapper verification clean");
        end
        else
        begin
            $display("letterbox_nearest_pixel_mapper verification failed");
        end
        $finish;
    end

endmodule
